// ----- hw/rtl/vc_pkg.sv -----
// ----------------------------------------------------------------------------
// vc_pkg
// Shared types and constants for the base-128 varint codec.
// ----------------------------------------------------------------------------
package vc_pkg;

  // Default geometry
  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_BYTES_DEF  = 10;

  // Fixed field widths
  localparam int WORD_W    = 64;
  localparam int BYTE_W    = 8;
  localparam int PAYLOAD_W = 7;
  localparam int COUNT_W   = 4;

  // Work queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_t;

  // One classified item as it waits for the back end
  typedef struct packed {
    kind_t                  kind;
    logic [WORD_W-1:0]      value;    // masked value to encode
    logic [PAYLOAD_W-1:0]   payload;  // low seven bits of a decode byte
    logic                   cont;     // continuation flag of a decode byte
  } entry_t;

endpackage

// ----- hw/rtl/vc_front.sv -----
// ----------------------------------------------------------------------------
// vc_front
// Input side: accepts beats and splits them into queue entries.
// ----------------------------------------------------------------------------
module vc_front #(
  parameter int VALUE_BITS = vc_pkg::VALUE_BITS_DEF
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [vc_pkg::WORD_W-1:0]     value_in,
  input  logic [vc_pkg::BYTE_W-1:0]     byte_in,
  output logic                          push_valid,
  input  logic                          push_ready,
  output vc_pkg::entry_t                push_entry
);

  // Mask the value to the configured width
  logic [vc_pkg::WORD_W-1:0] value_mask;
  assign value_mask = {vc_pkg::WORD_W{1'b1}} >> (vc_pkg::WORD_W - VALUE_BITS);

  // Classify the beat into an entry
  always_comb begin
    push_entry.kind    = vc_pkg::kind_t'(kind);
    push_entry.value   = value_in & value_mask;
    push_entry.payload = byte_in[vc_pkg::PAYLOAD_W-1:0];
    push_entry.cont    = byte_in[vc_pkg::BYTE_W-1];
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ----- hw/rtl/vc_queue.sv -----
// ----------------------------------------------------------------------------
// vc_queue
// Short first-in first-out queue of classified entries.
// ----------------------------------------------------------------------------
module vc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  vc_pkg::entry_t  push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output vc_pkg::entry_t  pop_entry
);

  localparam int PTR_W = $clog2(vc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(vc_pkg::QUEUE_DEPTH + 1);

  vc_pkg::entry_t slots [vc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(vc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(vc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(vc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/vc_back.sv -----
// ----------------------------------------------------------------------------
// vc_back
// Execution side: emits encoded bytes, accumulates decode bytes, and holds
// each result in an output register.
// ----------------------------------------------------------------------------
module vc_back #(
  parameter int VALUE_BITS = vc_pkg::VALUE_BITS_DEF,
  parameter int MAX_BYTES  = vc_pkg::MAX_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  output logic                           head_ready,
  input  vc_pkg::entry_t                 head,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           is_value,
  output logic [vc_pkg::BYTE_W-1:0]      byte_out,
  output logic [vc_pkg::WORD_W-1:0]      value_out,
  output logic [vc_pkg::COUNT_W-1:0]     byte_count,
  output logic                           overflow,
  output logic                           last
);

  localparam int WIDE_W  = vc_pkg::WORD_W + vc_pkg::PAYLOAD_W;
  localparam int SHIFT_W = 7;

  // Encode state
  logic                       enc_active;
  logic [VALUE_BITS-1:0]      enc_val;
  // Decode state
  logic [VALUE_BITS-1:0]      acc;
  logic [vc_pkg::COUNT_W-1:0] idx;

  logic                       adv;
  logic                       head_enc;
  logic                       head_dec;
  logic [VALUE_BITS-1:0]      cur;
  logic [VALUE_BITS-1:0]      rem;
  logic                       enc_go;
  logic [SHIFT_W-1:0]         shift;
  logic [WIDE_W-1:0]          wide;
  logic [vc_pkg::COUNT_W-1:0] count;
  logic                       ovf;
  logic                       dec_emit;
  logic                       dec_go;
  logic [VALUE_BITS-1:0]      acc_new;

  // Output register may take a new result
  assign adv      = !out_valid || out_ready;
  assign head_enc = head_valid && (head.kind == vc_pkg::KIND_ENCODE);
  assign head_dec = head_valid && (head.kind == vc_pkg::KIND_DECODE);

  // Encode: next seven-bit group from the working value or the queue head
  assign cur    = enc_active ? enc_val : head.value[VALUE_BITS-1:0];
  assign rem    = cur >> vc_pkg::PAYLOAD_W;
  assign enc_go = adv && (enc_active || head_enc);

  // Decode: place payload, check for bits past the value width or a byte past MAX_BYTES
  always_comb begin
    shift    = SHIFT_W'({3'b000, idx} * 7'd7);
    wide     = WIDE_W'(head.payload) << shift;
    count    = idx + 1'b1;
    ovf      = (|(wide >> VALUE_BITS)) ||
               (head.cont && (count >= vc_pkg::COUNT_W'(MAX_BYTES)));
    acc_new  = acc | wide[VALUE_BITS-1:0];
    dec_emit = ovf || !head.cont;
    dec_go   = !enc_active && head_dec && (!dec_emit || adv);
  end

  // Pop at the first byte of an encode or when a decode byte is done
  assign head_ready = (!enc_active && head_enc && adv) || dec_go;

  // Encode and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_active <= 1'b0;
      enc_val    <= '0;
      acc        <= '0;
      idx        <= '0;
    end else begin
      if (enc_go) begin
        enc_active <= |rem;
        enc_val    <= rem;
      end
      if (dec_go) begin
        if (dec_emit) begin
          acc <= '0;
          idx <= '0;
        end else begin
          acc <= acc_new;
          idx <= count;
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= enc_go || (dec_go && dec_emit);
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (enc_go) begin
      is_value   <= 1'b0;
      byte_out   <= {|rem, cur[vc_pkg::PAYLOAD_W-1:0]};
      value_out  <= '0;
      byte_count <= '0;
      overflow   <= 1'b0;
      last       <= ~|rem;
    end else if (dec_go && dec_emit) begin
      is_value   <= 1'b1;
      byte_out   <= '0;
      value_out  <= ovf ? '0 : vc_pkg::WORD_W'(acc_new);
      byte_count <= count;
      overflow   <= ovf;
      last       <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/varint_codec.sv -----
// ----------------------------------------------------------------------------
// varint_codec
// Unsigned base-128 varint encoder and decoder, low group first.
// ----------------------------------------------------------------------------
// An encode beat (kind 0) produces one output beat per encoded byte, one per
// cycle while the output is not stalled, 1 to 10 beats with last on the final
// one; a decode beat (kind 1) produces a result beat only on a terminating
// byte or on overflow. Input beats pass through a two-entry queue into the
// execution unit, so input is taken while an encode is still emitting, up to
// the queue depth. Encodes and decodes share the single output register.
// Results are registered.
module varint_codec #(
  parameter int VALUE_BITS = vc_pkg::VALUE_BITS_DEF,
  parameter int MAX_BYTES  = vc_pkg::MAX_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [vc_pkg::WORD_W-1:0]      value_in,
  input  logic [vc_pkg::BYTE_W-1:0]      byte_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           is_value,
  output logic [vc_pkg::BYTE_W-1:0]      byte_out,
  output logic [vc_pkg::WORD_W-1:0]      value_out,
  output logic [vc_pkg::COUNT_W-1:0]     byte_count,
  output logic                           overflow,
  output logic                           last
);

  logic           push_valid;
  logic           push_ready;
  vc_pkg::entry_t push_entry;
  logic           head_valid;
  logic           head_ready;
  vc_pkg::entry_t head;

  // Classify input beats
  vc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value_in  (value_in),
    .byte_in   (byte_in),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry)
  );

  // Decouple front and back
  vc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid (head_valid),
    .pop_ready (head_ready),
    .pop_entry (head)
  );

  // Execute and register results
  vc_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_ready(head_ready),
    .head      (head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_value  (is_value),
    .byte_out  (byte_out),
    .value_out (value_out),
    .byte_count(byte_count),
    .overflow  (overflow),
    .last      (last)
  );

endmodule

// ----- sim/varint_codec_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// varint_codec_check
// Watches both channels of the varint codec and predicts every output beat.
// Encodes are expanded into their base-128 byte groups, and decodes run
// through a copy of the accumulator and byte index. Each accepted output beat
// is compared field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module varint_codec_check
  import vc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_BYTES  = MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               kind,
  input  logic [WORD_W-1:0]  value_in,
  input  logic [BYTE_W-1:0]  byte_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               is_value,
  input  logic [BYTE_W-1:0]  byte_out,
  input  logic [WORD_W-1:0]  value_out,
  input  logic [COUNT_W-1:0] byte_count,
  input  logic               overflow,
  input  logic               last,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [WORD_W-1:0] VALUE_MASK =
    (VALUE_BITS >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct packed {
    logic               is_value;
    logic [BYTE_W-1:0]  byte_v;
    logic [WORD_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic               ovf;
    logic               last;
  } codec_beat_t;

  codec_beat_t       beat_q[$];
  codec_beat_t       got;
  codec_beat_t       want;
  logic [WORD_W-1:0] dec_acc;
  int                dec_idx;
  int                errors;

  // Split a value into 7-bit groups, low group first
  task automatic predict_encode(input logic [WORD_W-1:0] v_in);
    logic [WORD_W-1:0] v;
    codec_beat_t       r;
    bit                done;
    int                n;
    v    = v_in & VALUE_MASK;
    done = 1'b0;
    for (n = 0; n < 10 && !done; n++) begin
      r        = '0;
      r.byte_v = {1'b0, v[PAYLOAD_W-1:0]};
      v        = v >> PAYLOAD_W;
      r.byte_v[BYTE_W-1] = (v != 0);
      r.last   = (v == 0);
      done     = (v == 0);
      beat_q.push_back(r);
    end
  endtask

  // Fold one byte into the running decode; emit on end of sequence or overflow
  task automatic predict_decode(input logic [BYTE_W-1:0] b);
    logic [PAYLOAD_W-1:0] payload;
    logic                 cont;
    logic                 ovf;
    int                   shift;
    int                   count;
    codec_beat_t          r;
    payload = b[PAYLOAD_W-1:0];
    cont    = b[BYTE_W-1];
    shift   = dec_idx * PAYLOAD_W;
    count   = dec_idx + 1;
    ovf     = 1'b0;

    // payload bits that land above the value width are illegal
    if (shift >= VALUE_BITS)
      ovf = (payload != 0);
    else if (VALUE_BITS - shift < PAYLOAD_W)
      ovf = ((payload >> (VALUE_BITS - shift)) != 0);
    // a sequence may not continue past its last allowed byte
    if (cont && count >= MAX_BYTES)
      ovf = 1'b1;

    r          = '0;
    r.is_value = 1'b1;
    r.count    = COUNT_W'(count);
    r.last     = 1'b1;
    if (ovf) begin
      r.ovf   = 1'b1;
      dec_acc = '0;
      dec_idx = 0;
      beat_q.push_back(r);
    end else begin
      if (shift < WORD_W)
        dec_acc = (dec_acc | ({{(WORD_W-PAYLOAD_W){1'b0}}, payload} << shift)) & VALUE_MASK;
      if (cont) begin
        dec_idx = count;
      end else begin
        r.value = dec_acc;
        beat_q.push_back(r);
        dec_acc = '0;
        dec_idx = 0;
      end
    end
  endtask

  initial begin
    errors     = 0;
    dec_acc    = '0;
    dec_idx    = 0;
    fail_count = 0;
    pending    = 0;
  end

  // Score output beats first, then predict from the input beat of this edge
  always @(posedge clk) begin
    if (rst) begin
      beat_q.delete();
      dec_acc = '0;
      dec_idx = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.is_value = is_value;
        got.byte_v   = byte_out;
        got.value    = value_out;
        got.count    = byte_count;
        got.ovf      = overflow;
        got.last     = last;
        if (beat_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected beat is_value=%b byte=%h value=%h count=%0d ovf=%b last=%b",
                     $time, got.is_value, got.byte_v, got.value, got.count, got.ovf, got.last);
        end else begin
          want = beat_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch", $time);
              $display("  expected is_value=%b byte=%h value=%h count=%0d ovf=%b last=%b",
                       want.is_value, want.byte_v, want.value, want.count, want.ovf, want.last);
              $display("  actual   is_value=%b byte=%h value=%h count=%0d ovf=%b last=%b",
                       got.is_value, got.byte_v, got.value, got.count, got.ovf, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (kind == KIND_ENCODE)
          predict_encode(value_in);
        else
          predict_decode(byte_in);
      end
    end
    pending    <= beat_q.size();
    fail_count <= errors;
  end

endmodule

// ----- sim/varint_codec_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// varint_codec_test
// Stimulus and verdict for the base-128 varint codec.
// Runs directed encodes and decodes (boundary values, zero padding, encode
// in the middle of a decode, a full ten-byte value), then random values,
// well-formed byte sequences and noise bytes, with random stalls on both
// channels. Scoring is done by varint_codec_check.
// ----------------------------------------------------------------------------
module varint_codec_test;
  import vc_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic [WORD_W-1:0]  value_in;
  logic [BYTE_W-1:0]  byte_in;
  logic               out_valid;
  logic               out_ready;
  logic               is_value;
  logic [BYTE_W-1:0]  byte_out;
  logic [WORD_W-1:0]  value_out;
  logic [COUNT_W-1:0] byte_count;
  logic               overflow;
  logic               last;

  int fail_count;
  int pending;
  int beats_sent;
  int stall_left;
  int start_cnt;
  int sel;
  bit idle_on;

  varint_codec dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value_in  (value_in),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_value  (is_value),
    .byte_out  (byte_out),
    .value_out (value_out),
    .byte_count(byte_count),
    .overflow  (overflow),
    .last      (last)
  );

  varint_codec_check result_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value_in  (value_in),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_value  (is_value),
    .byte_out  (byte_out),
    .value_out (value_out),
    .byte_count(byte_count),
    .overflow  (overflow),
    .last      (last),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("[varint_codec] ERROR");
    $finish;
  end

  // Drop ready in random bursts while idling is enabled
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Present one beat, with an optional gap first, and hold until taken
  task automatic send_beat(input logic k, input logic [WORD_W-1:0] v,
                           input logic [BYTE_W-1:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value_in <= v;
    byte_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Unused field of each beat carries random junk
  task automatic enc(input logic [WORD_W-1:0] v);
    send_beat(KIND_ENCODE, v, BYTE_W'($urandom));
  endtask

  task automatic dec(input logic [BYTE_W-1:0] b);
    send_beat(KIND_DECODE, {$urandom, $urandom}, b);
  endtask

  // Hold off input until every predicted beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random value of random significant length, sometimes all ones
  function automatic logic [WORD_W-1:0] rand_value();
    logic [WORD_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0)
      v = '1;
    else
      v = v >> $urandom_range(0, 63);
    return v;
  endfunction

  // Well-formed byte sequence with random payload; the tenth byte is mostly
  // kept within range, and a final byte occasionally keeps continuing
  task automatic send_dec_seq(input int len);
    logic [BYTE_W-1:0] b;
    int                i;
    for (i = 0; i < len; i++) begin
      b = BYTE_W'($urandom);
      b[BYTE_W-1] = (i < len - 1);
      if (i == 9 && $urandom_range(0, 3) != 0)
        b[PAYLOAD_W-1:0] = PAYLOAD_W'($urandom_range(0, 1));
      if (i == len - 1 && $urandom_range(0, 9) == 0)
        b[BYTE_W-1] = 1'b1;
      dec(b);
      if (i < len - 1 && $urandom_range(0, 7) == 0)
        enc(rand_value());
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = KIND_ENCODE;
    value_in   = '0;
    byte_in    = '0;
    idle_on    = 1'b1;
    beats_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // boundary encodes: zero, first two-byte value, full ten-byte value
    enc(64'd0);
    enc(64'd128);
    enc('1);
    // single-byte decode at the top of its range
    dec(8'h7F);
    // overlong zero padding
    dec(8'h80);
    dec(8'h80);
    dec(8'h00);
    // encode in the middle of a decode leaves the decode intact
    dec(8'hFF);
    enc(64'h8000_0000_0000_0000);
    dec(8'h01);
    // largest value in ten bytes
    repeat (9) dec(8'hFF);
    dec(8'h01);

    drain();

    // random part: mid stretch and tail without idling
    start_cnt = beats_sent;
    while (beats_sent - start_cnt < 100) begin
      idle_on = !((beats_sent - start_cnt >= 35 && beats_sent - start_cnt < 50) ||
                  beats_sent - start_cnt >= 80);
      sel = $urandom_range(0, 9);
      if (sel < 3)
        enc(rand_value());
      else if (sel < 8)
        send_dec_seq(($urandom_range(0, 3) == 0) ? 10 : $urandom_range(1, 9));
      else
        dec(BYTE_W'($urandom_range(0, 255)));
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[varint_codec] OK");
    else
      $display("[varint_codec] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/vc_pkg.sv
hw/rtl/vc_front.sv
hw/rtl/vc_queue.sv
hw/rtl/vc_back.sv
hw/rtl/varint_codec.sv
sim/varint_codec_check.sv
sim/varint_codec_test.sv
